@@ sv/sgs_pkg.sv @@
package sgs_pkg;

    localparam int ACC_WIDTH = 64;

    // Controller to datapath commands
    typedef struct packed {
        logic shift_in;    // push a new sample into the window
        logic acc_clear;   // start a new output sum
        logic mac_en;      // accumulate one tap
        logic finish;      // round, saturate and load the output register
    } sgs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;    // output register holds an unsent result
    } sgs_stat_t;

endpackage

@@ sv/savitzky_golay_smoother_unit.sv @@
// Each sample request that completes the window gives one centre output or an edge run,
// stalled by output back-pressure; no new request is taken until the last output is loaded.
// Outputs come one at a time from the single shared multiply-accumulate walking the window taps.
// Edge runs give h+1 outputs, or 2h+1 when the window fills on the last sample of a record.
// Reset (rst_n, async low) clears the window pointer, fill count and half width (to 2);
// sample and weight storage are not cleared; only filled window entries ever feed a sum.
module savitzky_golay_smoother_unit
    import sgs_pkg::*;
#(
    parameter int MAX_HALF       = 31,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,      // half_width
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    // operation[0], sample, coef_row, coef_col, coef_value, zero pad
    input  logic [((SAMPLE_WIDTH + COEF_FRAC_BITS + 16 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // filtered, zero pad
    output logic       m_axis_tlast
);

    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int ROW_W     = $clog2(MAX_HALF + 1);
    localparam int COL_W     = $clog2(WIN_DEPTH);
    localparam int COEF_W    = COEF_FRAC_BITS + 4;
    localparam int OUT_W     = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int P_SMP     = 1;
    localparam int P_ROW     = P_SMP + SAMPLE_WIDTH;
    localparam int P_COL     = P_ROW + 5;
    localparam int P_VAL     = P_COL + 6;

    sgs_cmd_t                       cmd;
    sgs_stat_t                      stat;
    logic [4:0]                     half_width_reg;
    logic                           coef_we;
    logic [ROW_W-1:0]               rd_row;
    logic [COL_W-1:0]               rd_col;
    logic [COL_W-1:0]               rd_tap;
    logic                           out_last_in;
    logic signed [SAMPLE_WIDTH-1:0] filtered;

    // Hold the half-width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= 5'd2;
        end
        else if (cfg_we)
        begin
            half_width_reg <= cfg_wdata;
        end
    end

    sgs_ctrl #(.MAX_HALF(MAX_HALF)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_width  (half_width_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tdata[0]),
        .in_last     (s_axis_tlast),
        .in_row      (s_axis_tdata[P_ROW +: 5]),
        .in_col      (s_axis_tdata[P_COL +: 6]),
        .coef_we     (coef_we),
        .cmd         (cmd),
        .stat        (stat),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .rd_tap      (rd_tap),
        .out_last_in (out_last_in)
    );

    sgs_datapath #(
        .MAX_HALF       (MAX_HALF),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .sample_in   (s_axis_tdata[P_SMP +: SAMPLE_WIDTH]),
        .coef_we     (coef_we),
        .coef_wrow   (ROW_W'(s_axis_tdata[P_ROW +: 5])),
        .coef_wcol   (COL_W'(s_axis_tdata[P_COL +: 6])),
        .coef_wdata  (s_axis_tdata[P_VAL +: COEF_W]),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .rd_tap      (rd_tap),
        .out_last_in (out_last_in),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (filtered),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'($unsigned(filtered));

endmodule

@@ sv/sgs_datapath.sv @@
module sgs_datapath
    import sgs_pkg::*;
#(
    parameter int MAX_HALF       = 31,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int WIN_DEPTH      = 2 * MAX_HALF + 1,
    parameter int ROW_W          = $clog2(MAX_HALF + 1),
    parameter int COL_W          = $clog2(WIN_DEPTH),
    parameter int COEF_W         = COEF_FRAC_BITS + 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sgs_cmd_t                       cmd,
    output sgs_stat_t                      stat,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           coef_we,
    input  logic [ROW_W-1:0]               coef_wrow,
    input  logic [COL_W-1:0]               coef_wcol,
    input  logic signed [COEF_W-1:0]       coef_wdata,
    input  logic [ROW_W-1:0]               rd_row,
    input  logic [COL_W-1:0]               rd_col,
    input  logic [COL_W-1:0]               rd_tap,
    input  logic                           out_last_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_data,
    output logic                           out_last
);

    localparam int ADDR_W = $clog2((MAX_HALF + 1) * WIN_DEPTH);
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam logic signed [ACC_WIDTH-1:0] ACC_LIM = 64'sd1 <<< 62;

    logic signed [SAMPLE_WIDTH-1:0] win_mem [WIN_DEPTH];
    logic signed [COEF_W-1:0]       wmem [(MAX_HALF + 1) * WIN_DEPTH];
    logic [COL_W-1:0]               wptr_reg;
    logic [COL_W-1:0]               wptr_next;
    logic [COL_W:0]                 tap_sum;
    logic [COL_W-1:0]               tap_addr;
    logic signed [COEF_W-1:0]       w_reg;
    logic signed [SAMPLE_WIDTH-1:0] s_reg;
    logic                           mul_v_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           prod_v_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic signed [ACC_WIDTH-1:0]    acc_sum;
    logic signed [ACC_WIDTH-1:0]    acc_next;
    logic signed [ACC_WIDTH-1:0]    rnd;
    logic signed [ACC_WIDTH-1:0]    q;
    logic signed [SAMPLE_WIDTH-1:0] sat;
    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] data_reg;
    logic                           last_reg;
    logic [ADDR_W-1:0]              waddr;
    logic [ADDR_W-1:0]              raddr;

    assign waddr = ADDR_W'(coef_wrow * WIN_DEPTH + coef_wcol);
    assign raddr = ADDR_W'(rd_row * WIN_DEPTH + rd_col);

    // Map the window tap, oldest first, onto the circular sample store
    assign wptr_next = (wptr_reg == COL_W'(WIN_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign tap_sum   = {1'b0, wptr_reg} + {1'b0, rd_tap};
    assign tap_addr  = (tap_sum >= (COL_W+1)'(WIN_DEPTH))
                       ? COL_W'(tap_sum - (COL_W+1)'(WIN_DEPTH))
                       : tap_sum[COL_W-1:0];

    // Write and read the weight memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            wmem[waddr] <= coef_wdata;
        end
        w_reg <= wmem[raddr];
    end

    // Overwrite the oldest sample slot; read the tap in step with the weight
    always_ff @(posedge clk)
    begin
        if (cmd.shift_in)
        begin
            win_mem[wptr_reg] <= sample_in;
        end
        s_reg <= win_mem[tap_addr];
    end

    // Advance the window write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
        end
        else if (cmd.shift_in)
        begin
            wptr_reg <= wptr_next;
        end
    end

    // Saturating accumulate
    always_comb
    begin
        acc_sum = acc_reg + ACC_WIDTH'(prod_reg);
        if (acc_sum > ACC_LIM)
        begin
            acc_next = ACC_LIM;
        end
        else if (acc_sum < -ACC_LIM)
        begin
            acc_next = -ACC_LIM;
        end
        else
        begin
            acc_next = acc_sum;
        end
    end

    // Round to nearest and saturate
    always_comb
    begin
        rnd = acc_reg + (ACC_WIDTH'(1) <<< (COEF_FRAC_BITS - 1));
        q   = rnd >>> COEF_FRAC_BITS;
        if (q > ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1))
        begin
            sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        else if (q < -(64'sd1 <<< (SAMPLE_WIDTH - 1)))
        begin
            sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat = q[SAMPLE_WIDTH-1:0];
        end
    end

    // Advance the multiply pipe, the accumulator and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            mul_v_reg  <= cmd.mac_en;
            prod_v_reg <= mul_v_reg;
            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_v_reg)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.finish)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= w_reg * s_reg;
        if (cmd.finish)
        begin
            data_reg <= sat;
            last_reg <= out_last_in;
        end
    end

    assign stat.out_busy = valid_reg;
    assign out_valid     = valid_reg;
    assign out_data      = data_reg;
    assign out_last      = last_reg;

endmodule

@@ sv/sgs_ctrl.sv @@
module sgs_ctrl
    import sgs_pkg::*;
#(
    parameter int MAX_HALF = 31,
    parameter int ROW_W    = $clog2(MAX_HALF + 1),
    parameter int COL_W    = $clog2(2 * MAX_HALF + 1),
    parameter int CNT_W    = $clog2(2 * MAX_HALF + 2)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       half_width,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic             in_last,
    input  logic [4:0]       in_row,
    input  logic [5:0]       in_col,
    output logic             coef_we,
    output sgs_cmd_t         cmd,
    input  sgs_stat_t        stat,
    output logic [ROW_W-1:0] rd_row,
    output logic [COL_W-1:0] rd_col,
    output logic [COL_W-1:0] rd_tap,
    output logic             out_last_in
);

    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [COL_W-1:0] h_reg;
    logic [COL_W-1:0] len;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] stop_reg, stop_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       drain_reg, drain_next;
    logic             accept;
    logic [COL_W-1:0] hc;
    logic [CNT_W-1:0] fill_inc;
    logic             full_now;
    logic             was_full;
    logic [COL_W-1:0] mrow;
    logic [COL_W-1:0] mcol;
    logic [COL_W-1:0] base;

    assign hc  = (half_width > 5'(MAX_HALF)) ? COL_W'(MAX_HALF) : COL_W'(half_width);
    assign len = COL_W'(2 * h_reg + 1);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign coef_we  = accept && in_op && (in_row <= 5'(MAX_HALF))
                      && (in_col <= 6'(WIN_DEPTH - 1));

    assign fill_inc = (fill_reg < CNT_W'(WIN_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign full_now = fill_inc >= CNT_W'(2 * hc + 1);
    assign was_full = fill_reg >= CNT_W'(2 * hc + 1);

    // Mirror the upper rows onto the stored ones
    assign mrow = (row_reg <= h_reg) ? row_reg : COL_W'(2 * h_reg - row_reg);
    assign mcol = (row_reg <= h_reg) ? col_reg : COL_W'(2 * h_reg - col_reg);
    assign base = COL_W'(WIN_DEPTH) - len;

    assign rd_row      = ROW_W'(mrow);
    assign rd_col      = mcol;
    assign rd_tap      = COL_W'(base + col_reg);
    assign out_last_in = (row_reg == stop_reg);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        row_next   = row_reg;
        stop_next  = stop_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !in_op)
                begin
                    cmd.shift_in = 1'b1;
                    fill_next    = in_last ? '0 : fill_inc;
                    col_next     = '0;
                    cmd.acc_clear = 1'b1;
                    if (full_now)
                    begin
                        state_next = S_MAC;
                        row_next   = was_full ? hc : '0;
                        stop_next  = in_last ? COL_W'(2 * hc) : hc;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_en = 1'b1;
                if (col_reg == len - 1'b1)
                begin
                    state_next = S_DRAIN;
                    drain_next = '0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    cmd.acc_clear = 1'b1;
                    if (row_reg == stop_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Register the controller state and counters, and latch the half width while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            row_reg   <= '0;
            stop_reg  <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
            h_reg     <= COL_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            stop_reg  <= stop_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
            if (state_reg == S_IDLE)
            begin
                h_reg <= hc;
            end
        end
    end

endmodule

@@ tb/tb_savitzky_golay_smoother_unit.sv @@
module tb_savitzky_golay_smoother_unit;
    import sgs_pkg::*;

    localparam int HMAX    = 31;
    localparam int DEPTH   = 2 * HMAX + 1;
    localparam int ROWS    = HMAX + 1;
    localparam int LOAD_H  = 5;
    localparam int SETTLE  = 2 * HMAX + 20;
    localparam int STALL_LIMIT = 3000;

    typedef enum logic { OP_SAMPLE = 1'b0, OP_COEF = 1'b1 } op_e;

    typedef struct {
        op_e               op;
        logic signed [15:0] sample;
        logic              last;
        logic [4:0]        row;
        logic [5:0]        col;
        logic signed [19:0] value;
        logic              quiet;   // request known to give no output
    } request_t;

    typedef struct {
        logic [15:0] filtered;
        logic        last;
    } smoothed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // operation, sample, coef_row, coef_col, coef_value
    logic        s_axis_tlast = 1'b0;  // last_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // filtered
    logic        m_axis_tlast;         // last_result

    savitzky_golay_smoother_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Shadow state of the smoother
    logic signed [15:0] win_hist [DEPTH];
    longint             weights [ROWS][DEPTH];
    int                 fill_cnt;
    int                 half_w;
    smoothed_t          pending_outputs [$];
    int                 errors;
    bit                 calm_send;
    bit                 hold_req;
    int                 idle_cycles;

    function automatic logic [15:0] window_sum(int r, int h);
        longint acc;
        longint w;
        longint q;
        int len;
        int base;
        len = 2 * h + 1;
        base = DEPTH - len;
        acc = 0;
        for (int c = 0; c < len; c++)
        begin
            w = (r <= h) ? weights[r][c] : weights[2 * h - r][2 * h - c];
            acc = acc + w * longint'(win_hist[base + c]);
            if (acc > (64'sd1 <<< 62)) acc = 64'sd1 <<< 62;
            if (acc < -(64'sd1 <<< 62)) acc = -(64'sd1 <<< 62);
        end
        q = (acc + 64'sd32768) >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Advance the shadow state by one request; return outputs produced
    function automatic int smooth_request(request_t rq);
        int len;
        int prev;
        int n;
        smoothed_t o;
        len = 2 * half_w + 1;
        n = 0;
        if (rq.op == OP_COEF)
        begin
            if (rq.col < DEPTH) weights[rq.row][rq.col] = longint'(rq.value);
            return 0;
        end
        for (int i = 0; i < DEPTH - 1; i++) win_hist[i] = win_hist[i + 1];
        win_hist[DEPTH - 1] = rq.sample;
        prev = fill_cnt;
        if (fill_cnt < DEPTH) fill_cnt++;
        if (fill_cnt >= len)
        begin
            if (prev < len)
                for (int r = 0; r <= half_w; r++)
                begin
                    o.filtered = window_sum(r, half_w); o.last = 1'b0;
                    pending_outputs.push_back(o); n++;
                end
            else
            begin
                o.filtered = window_sum(half_w, half_w); o.last = 1'b0;
                pending_outputs.push_back(o); n++;
            end
        end
        if (rq.last)
        begin
            if (fill_cnt >= len)
                for (int r = half_w + 1; r < len; r++)
                begin
                    o.filtered = window_sum(r, half_w); o.last = 1'b0;
                    pending_outputs.push_back(o); n++;
                end
            fill_cnt = 0;
        end
        if (n > 0) pending_outputs[$].last = 1'b1;
        return n;
    endfunction

    // Offer one request, with random idle cycles, until accepted
    task automatic send_request(request_t rq);
        int n;
        while (!calm_send && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.value, rq.col, rq.row, rq.sample, rq.op};
        s_axis_tlast  <= rq.last;
        do @(posedge clk); while (!s_axis_tready);
        n = smooth_request(rq);
        if (rq.quiet && n != 0)
        begin
            $error("quiet request: expected 0 outputs, got %0d", n);
            errors++;
        end
    endtask

    task automatic send_sample(logic signed [15:0] s, logic lst);
        request_t rq;
        rq.op = OP_SAMPLE; rq.sample = s; rq.last = lst;
        rq.row = 5'($urandom); rq.col = 6'($urandom); rq.value = 20'($urandom);
        rq.quiet = 1'b0;
        send_request(rq);
    endtask

    task automatic send_coef(int row, int col, logic signed [19:0] v);
        request_t rq;
        rq.op = OP_COEF; rq.sample = 16'($urandom); rq.last = 1'($urandom);
        rq.row = 5'(row); rq.col = 6'(col); rq.value = v; rq.quiet = 1'b1;
        send_request(rq);
    endtask

    // Write half width once the pipeline has drained
    task automatic set_half_width(int h);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= h[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        half_w = h;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(7) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [19:0] rand_weight();
        if ($urandom_range(3) == 0) return 20'($urandom);
        return 20'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Records of random length, the last one possibly cut short, with the odd coefficient rewrite between samples
    task automatic random_records(int count, int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(max_len, 1);
            for (int i = 0; i < len && sent < count; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_coef($urandom_range(HMAX), $urandom_range(63), rand_weight());
                send_sample(rand_sample(), i == len - 1);
                sent++;
            end
        end
    endtask

    request_t directed [] ;

    // Stimulus
    initial
    begin
        errors = 0; fill_cnt = 0; half_w = 2; calm_send = 1'b0; hold_req = 1'b0;
        for (int i = 0; i < DEPTH; i++) win_hist[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every weight that the widths used below can read
        calm_send = 1'b1;
        for (int r = 0; r <= LOAD_H; r++)
            for (int c = 0; c <= 2 * LOAD_H; c++)
                send_coef(r, c, rand_weight());
        calm_send = 1'b0;

        directed = '{
            '{OP_SAMPLE, 16'sh7fff, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh7fff, 1'b1, 5'd0, 6'd0, 20'sd0, 1'b1},  // short record
            '{OP_COEF, 16'sh1234, 1'b1, 5'd31, 6'd63, 20'sh7ffff, 1'b1},  // column ignored
            '{OP_COEF, 16'sh0, 1'b0, 5'd0, 6'd0, 20'sh7ffff, 1'b1},
            '{OP_COEF, 16'sh0, 1'b0, 5'd2, 6'd2, 20'sh80000, 1'b1},
            '{OP_COEF, 16'sh0, 1'b0, 5'd1, 6'd4, 20'sh10000, 1'b1},
            '{OP_SAMPLE, 16'sh7fff, 1'b0, 5'd31, 6'd63, 20'sh7ffff, 1'b1},
            '{OP_SAMPLE, 16'sh8000, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0001, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'shffff, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0000, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b0},  // leading edge
            '{OP_SAMPLE, 16'sh7fff, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b0},  // centre
            '{OP_SAMPLE, 16'sh8000, 1'b1, 5'd0, 6'd0, 20'sd0, 1'b0},  // trailing edge
            '{OP_SAMPLE, 16'sh0100, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0200, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0300, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0400, 1'b0, 5'd0, 6'd0, 20'sd0, 1'b1},
            '{OP_SAMPLE, 16'sh0500, 1'b1, 5'd0, 6'd0, 20'sd0, 1'b0}   // fill on last
        };
        foreach (directed[i]) send_request(directed[i]);

        // Single-sample window, then the random part across several widths
        set_half_width(0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        random_records(20, 6);

        set_half_width(1);
        hold_req = 1'b1;
        random_records(30, 8);
        calm_send = 1'b1;
        set_half_width(2);
        random_records(30, 12);
        calm_send = 1'b0;

        // Widest loaded window: records of up to 15 samples, some long enough to fill and run on
        set_half_width(LOAD_H);
        random_records(15, 15);
        set_half_width(3);
        random_records(20, 10);
        s_axis_tvalid <= 1'b0;

        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            $error("%0d outputs never arrived", pending_outputs.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_savitzky_golay_smoother_unit: PASS");
        else
            $display("tb_savitzky_golay_smoother_unit: FAIL");
        $finish;
    end

    // Output side: random back-pressure, one long hold-off, compare
    initial
    begin : output_side
        int hold_left;
        bit held;
        smoothed_t want;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("unexpected output filtered=%0d", $signed(m_axis_tdata));
                    errors++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_axis_tdata !== want.filtered)
                    begin
                        $error("filtered: expected %0d, got %0d",
                               $signed(want.filtered), $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_result: expected %0b, got %0b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req && !held)
            begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm_send || ($urandom_range(99) >= 9);
        end
    end

    // Watchdog on cycles with no transfer on either side
    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_savitzky_golay_smoother_unit: FAIL");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
sv/sgs_pkg.sv
sv/sgs_datapath.sv
sv/sgs_ctrl.sv
sv/savitzky_golay_smoother_unit.sv
tb/tb_savitzky_golay_smoother_unit.sv
